### design/bcs_pkg.sv
// Shared types, codes and byte helpers for the streaming bad-character search.
package bcs_pkg;

    // Input transaction actions
    localparam logic [1:0] ACT_DATA  = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_START = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_ENDED = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_PAT_LOW  = 3'd0;
    localparam logic [2:0] CFG_PAT_HIGH = 3'd1;
    localparam logic [2:0] CFG_PAT_LEN  = 3'd2;
    localparam logic [2:0] CFG_CASE     = 3'd3;
    localparam logic [2:0] CFG_LIMIT    = 3'd4;

    localparam logic [15:0] LIMIT_RESET = 16'd8192;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] consumed_count;
    } result_t;

    // Fold lower-case letters to upper case unless exact matching is on
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic match_case);
        logic [7:0] r;
        r = c;
        if (!match_case && c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // Pick pattern byte i out of the 16-byte pattern word
    function automatic logic [7:0] pat_byte(input logic [127:0] pat, input logic [3:0] i);
        return pat[{i, 3'b000} +: 8];
    endfunction

endpackage

### design/bcs_window.sv
// Window shift register holding the newest stream bytes, with one selectable read tap.
module bcs_window
    import bcs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             shift_en,
    input  logic [7:0]       byte_in,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_byte,
    output logic [7:0]       newest
);

    logic [7:0] win_reg [DEPTH];

    // Advance the window by one byte, newest at the top
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[DEPTH-1] <= byte_in;
        end
    end

    assign rd_byte = win_reg[rd_idx];
    assign newest  = win_reg[DEPTH-1];

endmodule

### design/bcs_cmp.sv
// Shared byte compare unit with optional case folding.
module bcs_cmp
    import bcs_pkg::*;
(
    input  logic [7:0] a,
    input  logic [7:0] b,
    input  logic       match_case,
    output logic       eq
);

    // Fold both operands, then compare
    assign eq = (fold_byte(a, match_case) == fold_byte(b, match_case));

endmodule

### design/streaming_bad_character_search.sv
// Streaming bad-character search: the top level with sequencer, configuration and output.
//
// Usage: configure pattern_low/high, pattern_length, match_case and byte_limit through
// the cfg channel (valid/ready, ready is always high) while the block is idle. Stream
// transactions on the item channel: a start action opens a search, data actions
// carry stream bytes and an end action closes the stream. An item is taken when
// item_valid is high and item_stall is low.
// Each search ends in exactly one result on the result channel, unless a new start or a
// reset cuts it off: found, byte limit exceeded or stream ended, with the bytes consumed.
// Start, end and skipped data bytes leave the sequencer idle, ready for the next item.
// A data byte that completes a window stalls the item channel while the sequencer runs
// the right-to-left compares; on a mismatch it scans for the mismatching byte and, if
// needed, for the window's last byte, then decides the shift; when a result is due, an
// emit state follows. All compares share one fold-and-compare unit.
// Results leave through an output register; while it holds a stalled result the
// item channel stalls as well, and no result is ever dropped.
// Reset (rst_n, asynchronous, active low) restores the register defaults, ends any
// search and empties the output register; no clearing pass is needed.
module streaming_bad_character_search
    import bcs_pkg::*;
#(
    parameter int PAT_MAX = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int IDX_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam logic [4:0] PAT_MAX_W = 5'(PAT_MAX);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_CMP       = 6'b000010,
        S_SCAN_MM   = 6'b000100,
        S_SCAN_HEAD = 6'b001000,
        S_DECIDE    = 6'b010000,
        S_EMIT      = 6'b100000
    } state_t;

    // Configuration registers
    logic [63:0] pat_low_reg, pat_high_reg;
    logic [4:0]  pat_len_reg;
    logic        match_case_reg;
    logic [15:0] limit_reg;

    // Control state
    state_t      state_reg, state_next;
    logic        active_reg, active_next;
    logic [4:0]  skip_reg, skip_next;
    logic [15:0] consumed_reg, consumed_next;
    logic [3:0]  k_reg, k_next;
    logic [3:0]  pos_reg, pos_next;
    logic [3:0]  scan_j_reg, scan_j_next;
    logic [4:0]  dist_mm_reg, dist_mm_next;
    logic [4:0]  shift_reg, shift_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic        result_valid_reg, result_valid_next;

    // Payload state
    logic [7:0]  scan_byte_reg, scan_byte_next;
    result_t     result_reg, result_next;

    logic [127:0]     pattern;
    logic [4:0]       n;
    logic [3:0]       n_m1;
    logic [4:0]       base;
    logic [4:0]       rd_sum;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       win_rd, win_newest;
    logic             shift_en;
    logic [7:0]       cmp_a, cmp_b;
    logic             cmp_eq;
    logic             accept;
    logic             slot_free;
    logic [4:0]       skip_dec;
    logic             scan_done;
    logic [4:0]       scan_dist;
    logic [16:0]      reach;

    assign pattern   = {pat_high_reg, pat_low_reg};
    assign cfg_ready = 1'b1;

    // Clamp the pattern length into 1..PAT_MAX
    always_comb
    begin
        n = pat_len_reg;
        if (n == 5'd0)
        begin
            n = 5'd1;
        end
        else if (n > PAT_MAX_W)
        begin
            n = PAT_MAX_W;
        end
    end

    assign n_m1   = 4'(n - 5'd1);
    assign base   = PAT_MAX_W - n;
    assign rd_sum = base + {1'b0, k_reg};
    assign rd_idx = rd_sum[IDX_W-1:0];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg    <= '0;
            pat_high_reg   <= '0;
            pat_len_reg    <= 5'd1;
            match_case_reg <= 1'b1;
            limit_reg      <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PAT_LOW:  pat_low_reg    <= cfg_data;
                CFG_PAT_HIGH: pat_high_reg   <= cfg_data;
                CFG_PAT_LEN:  pat_len_reg    <= cfg_data[4:0];
                CFG_CASE:     match_case_reg <= cfg_data[0];
                CFG_LIMIT:    limit_reg      <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Input handshake
    assign slot_free  = !result_valid_reg || !result_stall;
    assign item_stall = (state_reg != S_IDLE) || !slot_free;
    assign accept     = item_valid && !item_stall;
    assign shift_en   = accept && (item.action == ACT_DATA) && active_reg;
    assign skip_dec   = (skip_reg != 5'd0) ? skip_reg - 5'd1 : 5'd0;

    bcs_window #(
        .DEPTH (PAT_MAX),
        .IDX_W (IDX_W)
    ) u_window (
        .clk      (clk),
        .shift_en (shift_en),
        .byte_in  (item.data_byte),
        .rd_idx   (rd_idx),
        .rd_byte  (win_rd),
        .newest   (win_newest)
    );

    // Route the shared compare unit
    assign cmp_a = (state_reg == S_CMP) ? win_rd : scan_byte_reg;
    assign cmp_b = pat_byte(pattern, (state_reg == S_CMP) ? k_reg : scan_j_reg);

    bcs_cmp u_cmp (
        .a          (cmp_a),
        .b          (cmp_b),
        .match_case (match_case_reg),
        .eq         (cmp_eq)
    );

    // Last-occurrence scan step
    always_comb
    begin
        scan_done = 1'b0;
        scan_dist = 5'd0;
        if (pos_reg == 4'd0)
        begin
            scan_done = 1'b1;
            scan_dist = 5'd1;
        end
        else if (cmp_eq)
        begin
            scan_done = 1'b1;
            scan_dist = {1'b0, pos_reg} - {1'b0, scan_j_reg};
        end
        else if (scan_j_reg == 4'd0)
        begin
            scan_done = 1'b1;
            scan_dist = {1'b0, pos_reg} + 5'd1;
        end
    end

    assign reach = {1'b0, consumed_reg} + {12'd0, shift_reg};

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        active_next       = active_reg;
        skip_next         = skip_reg;
        consumed_next     = consumed_reg;
        k_next            = k_reg;
        pos_next          = pos_reg;
        scan_j_next       = scan_j_reg;
        dist_mm_next      = dist_mm_reg;
        shift_next        = shift_reg;
        res_status_next   = res_status_reg;
        scan_byte_next    = scan_byte_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.action)
                        ACT_START:
                        begin
                            consumed_next = '0;
                            if ({11'd0, n} > limit_reg)
                            begin
                                result_next.status         = ST_LIMIT;
                                result_next.consumed_count = '0;
                                result_valid_next          = 1'b1;
                                active_next                = 1'b0;
                                skip_next                  = '0;
                            end
                            else
                            begin
                                skip_next   = n;
                                active_next = 1'b1;
                            end
                        end
                        ACT_END:
                        begin
                            if (active_reg)
                            begin
                                result_next.status         = ST_ENDED;
                                result_next.consumed_count = consumed_reg;
                                result_valid_next          = 1'b1;
                                active_next                = 1'b0;
                                skip_next                  = '0;
                            end
                        end
                        ACT_DATA:
                        begin
                            if (active_reg)
                            begin
                                consumed_next = consumed_reg + 16'd1;
                                skip_next     = skip_dec;
                                if (skip_dec == 5'd0)
                                begin
                                    k_next     = n_m1;
                                    state_next = S_CMP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CMP:
            begin
                if (cmp_eq)
                begin
                    if (k_reg == 4'd0)
                    begin
                        res_status_next = ST_FOUND;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        k_next = k_reg - 4'd1;
                    end
                end
                else
                begin
                    scan_byte_next = win_rd;
                    pos_next       = k_reg;
                    scan_j_next    = k_reg - 4'd1;
                    state_next     = S_SCAN_MM;
                end
            end
            S_SCAN_MM:
            begin
                if (scan_done)
                begin
                    dist_mm_next = scan_dist;
                    if (k_reg != n_m1)
                    begin
                        scan_byte_next = win_newest;
                        pos_next       = n_m1;
                        scan_j_next    = n_m1 - 4'd1;
                        state_next     = S_SCAN_HEAD;
                    end
                    else
                    begin
                        shift_next = scan_dist;
                        state_next = S_DECIDE;
                    end
                end
                else
                begin
                    scan_j_next = scan_j_reg - 4'd1;
                end
            end
            S_SCAN_HEAD:
            begin
                if (scan_done)
                begin
                    shift_next = (scan_dist > dist_mm_reg) ? scan_dist : dist_mm_reg;
                    state_next = S_DECIDE;
                end
                else
                begin
                    scan_j_next = scan_j_reg - 4'd1;
                end
            end
            S_DECIDE:
            begin
                if (reach > {1'b0, limit_reg})
                begin
                    res_status_next = ST_LIMIT;
                    state_next      = S_EMIT;
                end
                else
                begin
                    skip_next  = shift_reg;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    result_next.status         = res_status_reg;
                    result_next.consumed_count = consumed_reg;
                    result_valid_next          = 1'b1;
                    active_next                = 1'b0;
                    skip_next                  = '0;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            active_reg       <= 1'b0;
            skip_reg         <= '0;
            consumed_reg     <= '0;
            k_reg            <= '0;
            pos_reg          <= '0;
            scan_j_reg       <= '0;
            dist_mm_reg      <= '0;
            shift_reg        <= '0;
            res_status_reg   <= ST_FOUND;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_reg       <= active_next;
            skip_reg         <= skip_next;
            consumed_reg     <= consumed_next;
            k_reg            <= k_next;
            pos_reg          <= pos_next;
            scan_j_reg       <= scan_j_next;
            dist_mm_reg      <= dist_mm_next;
            shift_reg        <= shift_next;
            res_status_reg   <= res_status_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        scan_byte_reg <= scan_byte_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### design/bcs_checker.sv
// Port-level checker for the streaming bad-character search, bound to the top level.
module bcs_checker
    import bcs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        result_valid,
    input logic        result_stall,
    input result_t     result
);

    // Hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or vanished");

    // Block new items while a result waits on the receiver
    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |-> item_stall)
        else $error("item taken while result is stalled");

    // A match always covers at least one consumed byte
    a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_FOUND |-> result.consumed_count != 16'd0)
        else $error("found result with zero consumed bytes");

    // A new result follows an accepted item or a busy period
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall) || $past(item_stall))
        else $error("result appeared without a cause");

endmodule

bind streaming_bad_character_search bcs_checker u_bcs_checker (.*);
